>>> hdl/wgm_pkg.sv
// ----------------------------------------------------------------------------
// wgm_pkg
// Shared types and byte codes for the wildcard glob matcher.
// ----------------------------------------------------------------------------
package wgm_pkg;

	localparam logic [7:0] STAR_CH  = 8'h2A;
	localparam logic [7:0] QMARK_CH = 8'h3F;
	localparam logic [7:0] NUL_CH   = 8'h00;

	typedef enum logic [3:0] {
		ST_LOAD = 4'b0001,
		ST_RD   = 4'b0010,
		ST_EX   = 4'b0100,
		ST_DONE = 4'b1000
	} state_t;

	typedef enum logic [6:0] {
		OP_L1   = 7'b0000001,
		OP_L1Z  = 7'b0000010,
		OP_STAR = 7'b0000100,
		OP_SCAN = 7'b0001000,
		OP_L2   = 7'b0010000,
		OP_BQ   = 7'b0100000,
		OP_BS   = 7'b1000000
	} op_t;

endpackage

>>> hdl/wildcard_glob_matcher.sv
// ----------------------------------------------------------------------------
// wildcard_glob_matcher
// Loads a pattern and a target string byte by byte and reports whether the
// target matches the pattern ('*' any run, '?' one byte).
// ----------------------------------------------------------------------------
// Loading takes one byte per cycle. The target terminator starts the match
// pass, which walks the pattern and target memories with a remembered star
// position; each step is a memory read state (ST_RD) followed by an evaluate
// state (ST_EX), backtracking adds steps, and ST_DONE then posts the result.
// A string over MAX_LEN bytes skips the pass and reports too_long. No input
// item is taken during the match pass.
module wildcard_glob_matcher #(
	parameter int MAX_LEN = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] ch
	input  logic [0:0] s_tuser,   // [0] func
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata    // [0] match, [1] too_long, [7:2] zero
);

	localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
	localparam int LW = $clog2(MAX_LEN + 1);
	localparam int XW = LW + 2;

	wgm_pkg::state_t state_q;
	wgm_pkg::op_t    op_q;

	logic [LW-1:0] plen_q;
	logic [LW-1:0] tlen_q;
	logic          closed_q;
	logic          ovf_q;
	logic          res_q;
	logic          m_tvalid_q;
	logic [7:0]    m_tdata_q;

	logic [XW-1:0] pi_q;
	logic [XW-1:0] ti_q;
	logic [XW-1:0] pbk_q;
	logic [XW-1:0] tbk_q;

	logic [7:0] pat_mem [MAX_LEN];
	logic [7:0] tgt_mem [MAX_LEN];

	logic [7:0] pat_rd_s1;
	logic [7:0] tgt_rd_s1;
	logic       prng_s1;
	logic       trng_s1;

	logic          accept;
	logic          is_tgt;
	logic          ch_zero;
	logic          pat_we;
	logic          tgt_we;
	logic [XW-1:0] pa;
	logic [XW-1:0] ta;
	logic [7:0]    pv;
	logic [7:0]    tv;
	logic          p_star;
	logic          p_qm;
	logic          p_nul;
	logic          t_nul;
	logic          p_eq_t;

	assign s_tready = (state_q == wgm_pkg::ST_LOAD);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	assign accept  = s_tvalid && s_tready;
	assign is_tgt  = s_tuser[0];
	assign ch_zero = (s_tdata == wgm_pkg::NUL_CH);
	assign pat_we  = accept && !is_tgt && !closed_q && !ch_zero
		&& (plen_q < LW'(MAX_LEN));
	assign tgt_we  = accept && is_tgt && !ch_zero && (tlen_q < LW'(MAX_LEN));

	always_comb begin
		pa = (op_q == wgm_pkg::OP_BQ) ? pbk_q : pi_q;
		if (op_q == wgm_pkg::OP_L1) begin
			ta = pi_q;
		end else if (op_q == wgm_pkg::OP_BS) begin
			ta = tbk_q;
		end else begin
			ta = ti_q;
		end
	end

	always_ff @(posedge clk) begin
		if (pat_we) begin
			pat_mem[plen_q[AW-1:0]] <= s_tdata;
		end
		pat_rd_s1 <= pat_mem[pa[AW-1:0]];
		prng_s1   <= (pa < XW'(plen_q));
	end

	always_ff @(posedge clk) begin
		if (tgt_we) begin
			tgt_mem[tlen_q[AW-1:0]] <= s_tdata;
		end
		tgt_rd_s1 <= tgt_mem[ta[AW-1:0]];
		trng_s1   <= (ta < XW'(tlen_q));
	end

	assign pv     = prng_s1 ? pat_rd_s1 : wgm_pkg::NUL_CH;
	assign tv     = trng_s1 ? tgt_rd_s1 : wgm_pkg::NUL_CH;
	assign p_star = (pv == wgm_pkg::STAR_CH);
	assign p_qm   = (pv == wgm_pkg::QMARK_CH);
	assign p_nul  = (pv == wgm_pkg::NUL_CH);
	assign t_nul  = (tv == wgm_pkg::NUL_CH);
	assign p_eq_t = (pv == tv);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= wgm_pkg::ST_LOAD;
			op_q       <= wgm_pkg::OP_L1;
			plen_q     <= '0;
			tlen_q     <= '0;
			closed_q   <= 1'b0;
			ovf_q      <= 1'b0;
			res_q      <= 1'b0;
			m_tvalid_q <= 1'b0;
			m_tdata_q  <= '0;
			pi_q       <= '0;
			ti_q       <= '0;
			pbk_q      <= '0;
			tbk_q      <= '0;
		end else begin
			if (m_tvalid_q && m_tready && (state_q != wgm_pkg::ST_DONE)) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				wgm_pkg::ST_LOAD: begin
					if (accept) begin
						if (!is_tgt) begin
							if (!closed_q) begin
								if (ch_zero) begin
									closed_q <= 1'b1;
								end else if (pat_we) begin
									plen_q <= plen_q + LW'(1);
								end else begin
									ovf_q <= 1'b1;
								end
							end
						end else begin
							closed_q <= 1'b1;
							if (!ch_zero) begin
								if (tgt_we) begin
									tlen_q <= tlen_q + LW'(1);
								end else begin
									ovf_q <= 1'b1;
								end
							end else if (ovf_q) begin
								res_q   <= 1'b0;
								state_q <= wgm_pkg::ST_DONE;
							end else begin
								pi_q    <= '0;
								ti_q    <= '0;
								pbk_q   <= '0;
								tbk_q   <= '0;
								op_q    <= wgm_pkg::OP_L1;
								state_q <= wgm_pkg::ST_RD;
							end
						end
					end
				end
				wgm_pkg::ST_RD: begin
					state_q <= wgm_pkg::ST_EX;
				end
				wgm_pkg::ST_EX: begin
					state_q <= wgm_pkg::ST_RD;
					unique case (op_q)
						wgm_pkg::OP_L1: begin
							if (t_nul) begin
								if (p_star) begin
									pi_q <= pi_q + XW'(1);
									op_q <= wgm_pkg::OP_L1Z;
								end else begin
									res_q   <= p_nul;
									state_q <= wgm_pkg::ST_DONE;
								end
							end else if (p_star) begin
								ti_q <= pi_q;
								pi_q <= pi_q + XW'(1);
								op_q <= wgm_pkg::OP_STAR;
							end else if (!p_eq_t && !p_qm) begin
								res_q   <= 1'b0;
								state_q <= wgm_pkg::ST_DONE;
							end else begin
								pi_q <= pi_q + XW'(1);
							end
						end
						wgm_pkg::OP_L1Z: begin
							if (p_star) begin
								pi_q <= pi_q + XW'(1);
							end else begin
								res_q   <= p_nul;
								state_q <= wgm_pkg::ST_DONE;
							end
						end
						wgm_pkg::OP_STAR: begin
							if (p_star) begin
								pi_q <= pi_q + XW'(1);
							end else if (p_nul) begin
								res_q   <= 1'b1;
								state_q <= wgm_pkg::ST_DONE;
							end else if (t_nul) begin
								res_q   <= 1'b0;
								state_q <= wgm_pkg::ST_DONE;
							end else if (p_qm || p_eq_t) begin
								pbk_q <= pi_q;
								tbk_q <= ti_q;
								pi_q  <= pi_q + XW'(1);
								ti_q  <= ti_q + XW'(1);
								op_q  <= wgm_pkg::OP_L2;
							end else begin
								ti_q <= ti_q + XW'(1);
								op_q <= wgm_pkg::OP_SCAN;
							end
						end
						wgm_pkg::OP_SCAN: begin
							if (t_nul) begin
								res_q   <= 1'b0;
								state_q <= wgm_pkg::ST_DONE;
							end else if (!p_eq_t) begin
								ti_q <= ti_q + XW'(1);
							end else begin
								pbk_q <= pi_q;
								tbk_q <= ti_q;
								pi_q  <= pi_q + XW'(1);
								ti_q  <= ti_q + XW'(1);
								op_q  <= wgm_pkg::OP_L2;
							end
						end
						wgm_pkg::OP_L2: begin
							if (p_star) begin
								pi_q <= pi_q + XW'(1);
								op_q <= wgm_pkg::OP_STAR;
							end else if (!p_eq_t && !p_qm) begin
								if (t_nul) begin
									res_q   <= 1'b0;
									state_q <= wgm_pkg::ST_DONE;
								end else begin
									op_q <= wgm_pkg::OP_BQ;
								end
							end else if (t_nul) begin
								res_q   <= p_nul;
								state_q <= wgm_pkg::ST_DONE;
							end else begin
								pi_q <= pi_q + XW'(1);
								ti_q <= ti_q + XW'(1);
							end
						end
						wgm_pkg::OP_BQ: begin
							if (p_qm) begin
								pbk_q <= pbk_q + XW'(1);
								tbk_q <= tbk_q + XW'(1);
							end else begin
								pi_q  <= pbk_q;
								tbk_q <= tbk_q + XW'(1);
								op_q  <= wgm_pkg::OP_BS;
							end
						end
						wgm_pkg::OP_BS: begin
							if (p_eq_t) begin
								if (t_nul) begin
									res_q   <= p_nul;
									state_q <= wgm_pkg::ST_DONE;
								end else begin
									pi_q <= pi_q + XW'(1);
									ti_q <= tbk_q + XW'(1);
									op_q <= wgm_pkg::OP_L2;
								end
							end else if (t_nul) begin
								res_q   <= 1'b0;
								state_q <= wgm_pkg::ST_DONE;
							end else begin
								tbk_q <= tbk_q + XW'(1);
							end
						end
						default: begin
							op_q <= wgm_pkg::OP_L1;
						end
					endcase
				end
				wgm_pkg::ST_DONE: begin
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q  <= {6'b0, ovf_q, res_q && !ovf_q};
						plen_q     <= '0;
						tlen_q     <= '0;
						closed_q   <= 1'b0;
						ovf_q      <= 1'b0;
						state_q    <= wgm_pkg::ST_LOAD;
					end
				end
				default: begin
					state_q <= wgm_pkg::ST_LOAD;
				end
			endcase
		end
	end

endmodule

>>> bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Checks the wildcard glob matcher. The bench streams pattern and target
// bytes, runs its own glob predictor on every accepted item, and compares
// each posted verdict (match, too_long) against the oldest queued one. A
// short table of directed strings comes first, then random sessions; the
// source and sink stall at random for the first two thirds of the items.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int         MAX_LEN     = 64;
	localparam int         RAND_ITEMS  = 1150;
	localparam int         STALL_LIMIT = 100000;
	localparam logic [7:0] FILL_CH     = 8'h61;
	localparam bit         FN_PAT      = 1'b0;
	localparam bit         FN_TGT      = 1'b1;

	typedef enum logic [1:0] {WANT_PRED, WANT_NO, WANT_YES, WANT_LONG} want_t;

	typedef struct packed {
		logic too_long;
		logic match;
	} verdict_t;

	typedef struct {
		bit         fn;
		logic [7:0] ch;
		want_t      want;
	} str_item_t;

	typedef struct {
		string pat;
		int    pfill;
		bit    pclose;
		string stray;
		string tgt;
		int    tfill;
		want_t want;
	} dir_row_t;

	logic       clk      = 1'b0;
	logic       arst_n   = 1'b0;
	logic       s_tvalid = 1'b0;
	logic       s_tready;
	logic [7:0] s_tdata  = '0;
	logic [0:0] s_tuser  = '0;
	logic       m_tvalid;
	logic       m_tready = 1'b0;
	logic [7:0] m_tdata;

	wildcard_glob_matcher #(.MAX_LEN(MAX_LEN)) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	// predictor state
	logic [7:0]  pat_mem [MAX_LEN];
	logic [7:0]  tgt_mem [MAX_LEN];
	int unsigned pat_len  = 0;
	int unsigned tgt_len  = 0;
	bit          pat_done = 1'b0;
	bit          ovf_seen = 1'b0;

	str_item_t   byte_q[$];
	verdict_t    verdict_q[$];
	dir_row_t    dir_tab[20];
	int          n_total;
	int          n_issued    = 0;
	int          mismatches  = 0;
	int          quiet       = 0;
	int          src_idle    = 0;
	int          snk_idle    = 0;
	bit          s_took      = 1'b0;
	want_t       cur_want    = WANT_PRED;
	bit          fired;
	verdict_t    pred;
	verdict_t    got;
	str_item_t   nxt;

	function automatic logic [7:0] pat_byte(int unsigned i);
		return (i < pat_len) ? pat_mem[i] : wgm_pkg::NUL_CH;
	endfunction

	function automatic logic [7:0] tgt_byte(int unsigned i);
		return (i < tgt_len) ? tgt_mem[i] : wgm_pkg::NUL_CH;
	endfunction

	function automatic bit glob_match();
		int unsigned pi, ti, pbk, tbk;
		pi = 0;
		ti = 0;
		pbk = 0;
		tbk = 0;
		// leading run up to the first star
		while (1'b1) begin
			if (tgt_byte(pi) == wgm_pkg::NUL_CH) begin
				while (pat_byte(pi) == wgm_pkg::STAR_CH)
					pi++;
				return pat_byte(pi) == wgm_pkg::NUL_CH;
			end
			if (pat_byte(pi) == wgm_pkg::STAR_CH) begin
				ti = pi;
				while (pat_byte(pi) == wgm_pkg::STAR_CH)
					pi++;
				if (pat_byte(pi) == wgm_pkg::NUL_CH)
					return 1'b1;
				if (pat_byte(pi) != wgm_pkg::QMARK_CH) begin
					while (pat_byte(pi) != tgt_byte(ti)) begin
						ti++;
						if (tgt_byte(ti) == wgm_pkg::NUL_CH)
							return 1'b0;
					end
				end
				pbk = pi;
				tbk = ti;
				break;
			end
			if (pat_byte(pi) != tgt_byte(pi) && pat_byte(pi) != wgm_pkg::QMARK_CH)
				return 1'b0;
			pi++;
		end
		// past a star: match, fall back to the remembered positions
		while (1'b1) begin
			if (pat_byte(pi) == wgm_pkg::STAR_CH) begin
				while (pat_byte(pi) == wgm_pkg::STAR_CH)
					pi++;
				if (pat_byte(pi) == wgm_pkg::NUL_CH)
					return 1'b1;
				if (tgt_byte(ti) == wgm_pkg::NUL_CH)
					return 1'b0;
				if (pat_byte(pi) != wgm_pkg::QMARK_CH) begin
					while (pat_byte(pi) != tgt_byte(ti)) begin
						ti++;
						if (tgt_byte(ti) == wgm_pkg::NUL_CH)
							return 1'b0;
					end
				end
				pbk = pi;
				tbk = ti;
			end else if (pat_byte(pi) != tgt_byte(ti)
					&& pat_byte(pi) != wgm_pkg::QMARK_CH) begin
				if (tgt_byte(ti) == wgm_pkg::NUL_CH)
					return 1'b0;
				while (pat_byte(pbk) == wgm_pkg::QMARK_CH) begin
					pbk++;
					tbk++;
				end
				pi = pbk;
				while (1'b1) begin
					tbk++;
					if (pat_byte(pi) == tgt_byte(tbk))
						break;
					if (tgt_byte(tbk) == wgm_pkg::NUL_CH)
						return 1'b0;
				end
				ti = tbk;
			end
			if (tgt_byte(ti) == wgm_pkg::NUL_CH)
				return pat_byte(pi) == wgm_pkg::NUL_CH;
			pi++;
			ti++;
		end
		return 1'b0;
	endfunction

	function automatic void glob_step(input bit fn, input logic [7:0] ch,
			output bit res_out, output verdict_t res);
		res_out = 1'b0;
		res = '0;
		if (fn == FN_PAT) begin
			if (!pat_done) begin
				if (ch == wgm_pkg::NUL_CH) begin
					pat_done = 1'b1;
				end else if (pat_len < MAX_LEN) begin
					pat_mem[pat_len] = ch;
					pat_len++;
				end else begin
					ovf_seen = 1'b1;
				end
			end
			return;
		end
		pat_done = 1'b1;
		if (ch != wgm_pkg::NUL_CH) begin
			if (tgt_len < MAX_LEN) begin
				tgt_mem[tgt_len] = ch;
				tgt_len++;
			end else begin
				ovf_seen = 1'b1;
			end
			return;
		end
		res_out = 1'b1;
		res.too_long = ovf_seen;
		res.match = ovf_seen ? 1'b0 : glob_match();
		pat_len = 0;
		tgt_len = 0;
		pat_done = 1'b0;
		ovf_seen = 1'b0;
	endfunction

	task automatic add_item(input bit fn, input logic [7:0] ch, input want_t w);
		str_item_t it;
		it.fn = fn;
		it.ch = ch;
		it.want = w;
		byte_q.push_back(it);
	endtask

	task automatic add_text(input bit fn, input string s, input int fill);
		for (int i = 0; i < s.len(); i++)
			add_item(fn, s[i], WANT_PRED);
		repeat (fill)
			add_item(fn, FILL_CH, WANT_PRED);
	endtask

	function automatic logic [7:0] rand_letter();
		if ($urandom_range(0, 99) < 10)
			return 8'($urandom_range(1, 255));
		return FILL_CH + 8'($urandom_range(0, 2));
	endfunction

	function automatic int rand_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 85)
			return $urandom_range(0, 8);
		if (r < 96)
			return $urandom_range(9, MAX_LEN);
		return $urandom_range(MAX_LEN + 1, MAX_LEN + 6);
	endfunction

	task automatic add_session();
		logic [7:0] pat[$];
		logic [7:0] tgt[$];
		int         r;
		int         n;
		n = rand_len();
		repeat (n) begin
			r = $urandom_range(0, 99);
			if (r < 25)
				pat.push_back(wgm_pkg::STAR_CH);
			else if (r < 40)
				pat.push_back(wgm_pkg::QMARK_CH);
			else
				pat.push_back(rand_letter());
		end
		if ($urandom_range(0, 99) < 65) begin
			foreach (pat[i]) begin
				if (pat[i] == wgm_pkg::STAR_CH)
					repeat ($urandom_range(0, 3)) tgt.push_back(rand_letter());
				else if (pat[i] == wgm_pkg::QMARK_CH)
					tgt.push_back(rand_letter());
				else
					tgt.push_back(pat[i]);
			end
			if (tgt.size() > 0 && $urandom_range(0, 99) < 25)
				tgt[$urandom_range(0, tgt.size() - 1)] = rand_letter();
		end else begin
			n = rand_len();
			repeat (n) tgt.push_back(rand_letter());
		end
		foreach (pat[i])
			add_item(FN_PAT, pat[i], WANT_PRED);
		if ($urandom_range(0, 99) >= 10)
			add_item(FN_PAT, wgm_pkg::NUL_CH, WANT_PRED);
		if ($urandom_range(0, 99) < 8)
			repeat ($urandom_range(1, 3))
				add_item(FN_PAT, 8'($urandom_range(0, 255)), WANT_PRED);
		foreach (tgt[i])
			add_item(FN_TGT, tgt[i], WANT_PRED);
		add_item(FN_TGT, wgm_pkg::NUL_CH, WANT_PRED);
		if ($urandom_range(0, 99) < 4)
			repeat ($urandom_range(1, 6))
				add_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)), WANT_PRED);
	endtask

	task automatic build_stimulus();
		int n_dir;
		dir_tab = '{
			'{"",        0,  1'b1, "",     "",         0,  WANT_YES},
			'{"",        0,  1'b1, "",     "a",        0,  WANT_NO},
			'{"*",       0,  1'b1, "",     "",         0,  WANT_YES},
			'{"?",       0,  1'b1, "",     "",         0,  WANT_NO},
			'{"abc",     0,  1'b1, "",     "abc",      0,  WANT_YES},
			'{"abc",     0,  1'b1, "",     "abd",      0,  WANT_NO},
			'{"ABC",     0,  1'b1, "",     "abc",      0,  WANT_NO},
			'{"\001\377\200", 0, 1'b1, "", "\001\377\200", 0, WANT_YES},
			'{"a*c",     0,  1'b1, "",     "abbbc",    0,  WANT_PRED},
			'{"*?*",     0,  1'b1, "",     "x",        0,  WANT_PRED},
			'{"a*b?d*e", 0,  1'b1, "",     "aXbcdYYe", 0,  WANT_PRED},
			'{"*ab*ab",  0,  1'b1, "",     "abababab", 0,  WANT_PRED},
			'{"??*",     0,  1'b1, "",     "a",        0,  WANT_PRED},
			'{"a**b",    0,  1'b1, "",     "ab",       0,  WANT_PRED},
			'{"a?",      0,  1'b0, "",     "ab",       0,  WANT_PRED},
			'{"a",       0,  1'b1, "zz",   "a",        0,  WANT_PRED},
			'{"",        64, 1'b1, "",     "",         64, WANT_YES},
			'{"",        65, 1'b1, "",     "a",        0,  WANT_LONG},
			'{"*",       0,  1'b1, "",     "",         65, WANT_LONG},
			'{"*",       0,  1'b1, "",     "",         64, WANT_YES}
		};
		foreach (dir_tab[i]) begin
			add_text(FN_PAT, dir_tab[i].pat, dir_tab[i].pfill);
			if (dir_tab[i].pclose)
				add_item(FN_PAT, wgm_pkg::NUL_CH, WANT_PRED);
			if (dir_tab[i].stray != "") begin
				add_text(FN_PAT, dir_tab[i].stray, 0);
				add_item(FN_PAT, wgm_pkg::NUL_CH, WANT_PRED);
			end
			add_text(FN_TGT, dir_tab[i].tgt, dir_tab[i].tfill);
			add_item(FN_TGT, wgm_pkg::NUL_CH, dir_tab[i].want);
		end
		n_dir = byte_q.size();
		while (byte_q.size() - n_dir < RAND_ITEMS)
			add_session();
		n_total = byte_q.size();
	endtask

	// drive at the falling edge
	always @(negedge clk) begin
		if (arst_n) begin
			if (n_issued < n_total / 3) begin
				src_idle = 13;
				snk_idle = 81;
			end else if (n_issued < 2 * n_total / 3) begin
				src_idle = 81;
				snk_idle = 13;
			end else begin
				src_idle = 0;
				snk_idle = 0;
			end
			if (!s_tvalid || s_took) begin
				if (byte_q.size() != 0 && $urandom_range(0, 99) >= src_idle) begin
					nxt = byte_q.pop_front();
					n_issued++;
					cur_want = nxt.want;
					s_tvalid <= 1'b1;
					s_tdata  <= nxt.ch;
					s_tuser  <= nxt.fn;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
			m_tready <= ($urandom_range(0, 99) >= snk_idle);
		end
	end

	// sample at the rising edge
	always @(posedge clk) begin
		s_took = arst_n && s_tvalid && s_tready;
		if (s_took) begin
			glob_step(s_tuser[0], s_tdata, fired, pred);
			if (fired) begin
				case (cur_want)
					WANT_YES:  pred = '{too_long: 1'b0, match: 1'b1};
					WANT_NO:   pred = '{too_long: 1'b0, match: 1'b0};
					WANT_LONG: pred = '{too_long: 1'b1, match: 1'b0};
					default:   ;
				endcase
				verdict_q.push_back(pred);
			end
		end
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata[1:0];
			if (verdict_q.size() == 0) begin
				$display("%0t: expected no item, got match %0d too_long %0d",
					$time, got.match, got.too_long);
				mismatches++;
			end else begin
				pred = verdict_q.pop_front();
				if (got.match !== pred.match) begin
					$display("%0t: match expected %0d got %0d", $time, pred.match, got.match);
					mismatches++;
				end
				if (got.too_long !== pred.too_long) begin
					$display("%0t: too_long expected %0d got %0d",
						$time, pred.too_long, got.too_long);
					mismatches++;
				end
				if (m_tdata[7:2] !== 6'd0) begin
					$display("%0t: pad bits expected 0 got %0h", $time, m_tdata[7:2]);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet <= 0;
		end else if (quiet >= STALL_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

	initial begin
		build_stimulus();
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		while (byte_q.size() != 0 || s_tvalid)
			@(posedge clk);
		while (verdict_q.size() != 0)
			@(posedge clk);
		repeat (50) @(posedge clk);
		if (mismatches == 0 && !m_tvalid)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

>>> filelist.f
hdl/wgm_pkg.sv
hdl/wildcard_glob_matcher.sv
bench/testbench.sv
